// ===== hdl/hsvor_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsvor_pkg;

  localparam int FRAC_BITS = 16;

  // Hue scale: 1/64 degree
  localparam int HUE_SEXT = 3840;
  localparam int HUE_FULL = 23040;

  // Reciprocal table for 8-bit divisors, scaled by 2^RECIP_SHIFT
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // Which component a pass replaces
  localparam int OVR_VALUE = 0;
  localparam int OVR_SAT   = 1;
  localparam int OVR_HUE   = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLES = 2'd0;
  localparam logic [1:0] REG_HUE     = 2'd1;
  localparam logic [1:0] REG_SAT     = 2'd2;
  localparam logic [1:0] REG_VAL     = 2'd3;

  typedef logic [RECIP_W-1:0] recip_t;
  typedef recip_t recip_tab_t [256];

  // floor(2^RECIP_SHIFT / d) by shift-subtract; entry 0 is unused
  function automatic recip_tab_t recip_table();
    recip_tab_t  tab;
    logic [9:0]  rem;
    recip_t      quo;
    tab[0] = '0;
    for (int d = 1; d < 256; d++) begin
      rem = '0;
      quo = '0;
      for (int b = RECIP_SHIFT; b >= 0; b--) begin
        rem = {rem[8:0], (b == RECIP_SHIFT)};
        if (rem >= 10'(d)) begin
          rem    = rem - 10'(d);
          quo[b] = 1'b1;
        end
      end
      tab[d] = quo;
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = recip_table();

endpackage

`default_nettype wire

// ===== hdl/hsv_override_recolor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HSV override recolor. Each ARGB word is reported as hue (1/64 degree),
// saturation and value (Q1.FRACTION_BITS), and recolored by up to three
// override passes in a fixed order: value, saturation, hue. Each pass
// converts the current RGB to HSV, swaps in the enabled component and
// converts back with rounding; a pass that is off hands its pixel through.
// Alpha is carried unchanged. The pipeline takes one word every clock unless
// a stall holds it back; it has three passes of ten stages (five for RGB to
// HSV, five for the HSV to RGB multipliers) plus the output register.
// A stall on the output holds only the stages that are full; empty stages
// keep filling, so the input runs until the pipeline is full. Write the
// configuration registers only while no word is in flight.
module hsv_override_recolor_unit #(
  parameter int FRACTION_BITS = hsvor_pkg::FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_alpha,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_alpha,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [14:0]      out_src_hue,
  output logic [16:0]      out_src_saturation,
  output logic [16:0]      out_src_value,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  localparam int F   = FRACTION_BITS;
  localparam int FW  = F + 1;
  localparam int SW1 = 8 + 15 + 2 * FW;

  // Configuration registers
  logic [2:0]  enables_r;
  logic [14:0] hue_r;
  logic [16:0] sat_r, val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r <= '0;
      hue_r     <= '0;
      sat_r     <= '0;
      val_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hsvor_pkg::REG_ENABLES: enables_r <= cfg_data[2:0];
        hsvor_pkg::REG_HUE:     hue_r     <= cfg_data[14:0];
        hsvor_pkg::REG_SAT:     sat_r     <= cfg_data;
        hsvor_pkg::REG_VAL:     val_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pass chain
  logic           p0_valid, p0_stall, p1_valid, p1_stall, p2_valid, p2_stall;
  logic [7:0]     p0_r, p0_g, p0_b, p1_r, p1_g, p1_b, p2_r, p2_g, p2_b;
  logic [7:0]     p0_side;
  logic [14:0]    p0_hue;
  logic [FW-1:0]  p0_sat, p0_val;
  logic [SW1-1:0] p1_side, p2_side;

  hsvor_pass #(.F(F), .WHICH(hsvor_pkg::OVR_VALUE), .SW(8)) u_pass_val (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .up_side  (in_alpha),
    .ovr_en   (enables_r[0]),
    .repl     (val_r),
    .dn_valid (p0_valid),
    .dn_stall (p0_stall),
    .red_o    (p0_r),
    .green_o  (p0_g),
    .blue_o   (p0_b),
    .dn_side  (p0_side),
    .src_hue  (p0_hue),
    .src_sat  (p0_sat),
    .src_val  (p0_val)
  );

  // The first pass sees the source pixel: carry its HSV to the end
  hsvor_pass #(.F(F), .WHICH(hsvor_pkg::OVR_SAT), .SW(SW1)) u_pass_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p0_valid),
    .up_stall (p0_stall),
    .red      (p0_r),
    .green    (p0_g),
    .blue     (p0_b),
    .up_side  ({p0_side, p0_hue, p0_sat, p0_val}),
    .ovr_en   (enables_r[1]),
    .repl     (sat_r),
    .dn_valid (p1_valid),
    .dn_stall (p1_stall),
    .red_o    (p1_r),
    .green_o  (p1_g),
    .blue_o   (p1_b),
    .dn_side  (p1_side),
    .src_hue  (),
    .src_sat  (),
    .src_val  ()
  );

  hsvor_pass #(.F(F), .WHICH(hsvor_pkg::OVR_HUE), .SW(SW1)) u_pass_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p1_valid),
    .up_stall (p1_stall),
    .red      (p1_r),
    .green    (p1_g),
    .blue     (p1_b),
    .up_side  (p1_side),
    .ovr_en   (enables_r[2]),
    .repl     (17'(hue_r)),
    .dn_valid (p2_valid),
    .dn_stall (p2_stall),
    .red_o    (p2_r),
    .green_o  (p2_g),
    .blue_o   (p2_b),
    .dn_side  (p2_side),
    .src_hue  (),
    .src_sat  (),
    .src_val  ()
  );

  // Output register: advance when empty or when the word is taken
  logic           out_valid_r, out_load;
  logic [7:0]     alpha_r, red_r, green_r, blue_r;
  logic [14:0]    hue_src_r;
  logic [FW-1:0]  sat_src_r, val_src_r;

  assign out_load = !out_valid_r || !out_stall;
  assign p2_stall = !out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      alpha_r   <= p2_side[SW1-1 -: 8];
      hue_src_r <= p2_side[2*FW +: 15];
      sat_src_r <= p2_side[FW +: FW];
      val_src_r <= p2_side[0 +: FW];
      red_r     <= p2_r;
      green_r   <= p2_g;
      blue_r    <= p2_b;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_alpha          = alpha_r;
  assign out_red            = red_r;
  assign out_green          = green_r;
  assign out_blue           = blue_r;
  assign out_src_hue        = hue_src_r;
  assign out_src_saturation = 17'(sat_src_r);
  assign out_src_value      = 17'(val_src_r);

`ifndef SYNTHESIS
  localparam logic [FW-1:0] ONE = FW'(1) << F;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_src_hue < 15'(hsvor_pkg::HUE_FULL)))
    else $error("source hue not wrapped below a full turn");

  a_sv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sat_src_r <= ONE) && (val_src_r <= ONE))
    else $error("source saturation or value above 1.0");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> $stable(enables_r) && $stable(hue_r))
    else $error("configuration changed without a write");
`endif

endmodule

`default_nettype wire

// ===== hdl/hsvor_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// q = floor((a * 2^SHIFT + den/2) / den), den an 8-bit value, four stages.
// Estimate with a truncated reciprocal, then fix up by at most two.
module hsvor_div #(
  parameter int AW    = 8,
  parameter int SHIFT = 16,
  parameter int QW    = 17
) (
  input  wire logic          clk,
  input  wire logic [3:0]    en,
  input  wire logic [AW-1:0] a,
  input  wire logic [7:0]    den,
  output logic      [QW-1:0] q
);

  localparam int NW  = AW + SHIFT + 1;
  localparam int PW  = AW + hsvor_pkg::RECIP_W;
  localparam int MW  = QW + 8;
  localparam int RSH = hsvor_pkg::RECIP_SHIFT - SHIFT;

  logic [AW-1:0]             a1_r;
  logic [7:0]                den1_r, den2_r, den3_r;
  hsvor_pkg::recip_t         rcp1_r;
  logic [QW-1:0]             q0_2_r, q0_3_r, q_r;
  logic [NW-1:0]             num2_r, num3_r;
  logic [MW-1:0]             m3_r;
  logic [PW-1:0]             prod;
  logic [NW-1:0]             num;
  logic [NW-1:0]             rem;
  logic                      c1, c2;

  always_comb begin
    prod = PW'(a1_r) * PW'(rcp1_r);
    num  = (NW'(a1_r) << SHIFT) + NW'(den1_r >> 1);
    rem  = num3_r - NW'(m3_r);
    c1   = (rem >= NW'(den3_r));
    c2   = (rem >= (NW'(den3_r) << 1));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1_r   <= a;
      den1_r <= den;
      rcp1_r <= hsvor_pkg::RECIP[den];
    end
    if (en[1]) begin
      q0_2_r <= QW'(prod >> RSH);
      num2_r <= num;
      den2_r <= den1_r;
    end
    if (en[2]) begin
      m3_r   <= MW'(q0_2_r) * MW'(den2_r);
      q0_3_r <= q0_2_r;
      num3_r <= num2_r;
      den3_r <= den2_r;
    end
    if (en[3]) begin
      q_r <= q0_3_r + QW'(c1) + QW'(c2);
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== hdl/hsvor_analyze.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RGB to HSV: one stage of max/min/sextant, then three dividers in parallel.
module hsvor_analyze #(
  parameter int F  = hsvor_pkg::FRAC_BITS,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_stall,
  input  wire logic [7:0]    red,
  input  wire logic [7:0]    green,
  input  wire logic [7:0]    blue,
  input  wire logic [SW-1:0] up_side,
  output logic               dn_valid,
  input  wire logic          dn_stall,
  output logic      [14:0]   hue,
  output logic      [F:0]    sat,
  output logic      [F:0]    val,
  output logic      [SW-1:0] dn_side
);

  localparam int NS  = 5;
  localparam int SXW = SW + 2;

  logic [NS-1:0]  v_r;
  logic [NS:0]    en;
  logic [SXW-1:0] side_r [NS];
  logic [7:0]     mx, mn, d;
  logic [10:0]    x;
  logic [14:0]    ah;
  logic [7:0]     mx0_r, d0_r;
  logic [14:0]    ah0_r;
  logic [14:0]    qh;
  logic [F:0]     qs, qv;
  logic           zmx, zd;

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS] = !dn_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[NS-1];

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;
    if (red == mx) begin
      if (green >= blue) x = 11'(green - blue);
      else x = 11'(d) * 11'd6 - 11'(blue - green);
    end else if (green == mx) begin
      x = 11'(d) * 11'd2 + 11'(blue) - 11'(red);
    end else begin
      x = 11'(d) * 11'd4 + 11'(red) - 11'(green);
    end
    ah = (15'(x) << 4) - 15'(x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mx0_r     <= mx;
      d0_r      <= d;
      ah0_r     <= ah;
      side_r[0] <= {up_side, (mx == 8'd0), (d == 8'd0)};
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) side_r[k] <= side_r[k-1];
    end
  end

  hsvor_div #(.AW(8), .SHIFT(F), .QW(F + 1)) u_div_val (
    .clk (clk),
    .en  (en[4:1]),
    .a   (mx0_r),
    .den (8'd255),
    .q   (qv)
  );

  hsvor_div #(.AW(8), .SHIFT(F), .QW(F + 1)) u_div_sat (
    .clk (clk),
    .en  (en[4:1]),
    .a   (d0_r),
    .den (mx0_r),
    .q   (qs)
  );

  hsvor_div #(.AW(15), .SHIFT(8), .QW(15)) u_div_hue (
    .clk (clk),
    .en  (en[4:1]),
    .a   (ah0_r),
    .den (d0_r),
    .q   (qh)
  );

  assign zmx = side_r[NS-1][1];
  assign zd  = side_r[NS-1][0];

  // Grey gives hue 0; black gives saturation 0; wrap a full-circle hue
  always_comb begin
    if (zd) hue = '0;
    else if (qh >= 15'(hsvor_pkg::HUE_FULL)) hue = qh - 15'(hsvor_pkg::HUE_FULL);
    else hue = qh;
    sat     = zmx ? '0 : qs;
    val     = qv;
    dn_side = side_r[NS-1][SXW-1:2];
  end

endmodule

`default_nettype wire

// ===== hdl/hsvor_synth.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HSV to RGB through the sextant p/q/t rule, five stages.
module hsvor_synth #(
  parameter int F  = hsvor_pkg::FRAC_BITS,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_stall,
  input  wire logic [14:0]   hue,
  input  wire logic [F:0]    sat,
  input  wire logic [F:0]    val,
  input  wire logic [SW-1:0] up_side,
  output logic               dn_valid,
  input  wire logic          dn_stall,
  output logic      [7:0]    red,
  output logic      [7:0]    green,
  output logic      [7:0]    blue,
  output logic      [SW-1:0] dn_side
);

  localparam int NS  = 5;
  localparam int FW  = F + 1;
  localparam int XW  = F + 13;
  localparam int YW  = F + 5;
  localparam int K15 = YW + 4;
  localparam int MW  = F + 6;
  localparam int PW  = YW + MW;
  localparam int GW  = 2 * F + 2;
  localparam int RW  = 2 * F + 10;
  localparam logic [MW-1:0] M15 = MW'(((64'd1 << K15) + 64'd14) / 64'd15);
  localparam logic [FW-1:0] ONE = FW'(1) << F;
  localparam logic [RW-1:0] HALF = RW'(1) << (2 * F - 1);
  localparam logic [14:0]   SX1 = 15'(hsvor_pkg::HUE_SEXT);
  localparam logic [14:0]   SX2 = 15'(2 * hsvor_pkg::HUE_SEXT);
  localparam logic [14:0]   SX3 = 15'(3 * hsvor_pkg::HUE_SEXT);
  localparam logic [14:0]   SX4 = 15'(4 * hsvor_pkg::HUE_SEXT);
  localparam logic [14:0]   SX5 = 15'(5 * hsvor_pkg::HUE_SEXT);

  logic [NS-1:0]  v_r;
  logic [NS:0]    en;
  logic [SW-1:0]  side_r [NS];

  logic [14:0]    hm;
  logic [2:0]     k;
  logic [11:0]    f;
  logic [2:0]     k0_r, k1_r, k2_r, k3_r;
  logic [11:0]    f0_r;
  logic [FW-1:0]  s0_r, v0_r, s1_r, v1_r, s2_r, v2_r;
  logic [XW-1:0]  xa, xb;
  logic [YW-1:0]  ya1_r, yb1_r;
  logic [PW-1:0]  pa, pb;
  logic [FW-1:0]  sf2_r, sg2_r;
  logic [GW-1:0]  pv3_r, pp3_r, pq3_r, pt3_r;
  logic [7:0]     cv, cp, cq, ct;
  logic [7:0]     r4_r, g4_r, b4_r;

  function automatic logic [7:0] chan(input logic [GW-1:0] prod);
    logic [RW-1:0] w;
    w = (RW'(prod) << 8) - RW'(prod) + HALF;
    return 8'(w >> (2 * F));
  endfunction

  always_comb begin
    en[NS] = !dn_stall;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[NS-1];

  // Reduce hue below a full turn, split into sextant and fraction
  always_comb begin
    hm = (hue >= 15'(hsvor_pkg::HUE_FULL)) ? hue - 15'(hsvor_pkg::HUE_FULL) : hue;
    if (hm >= SX5) begin
      k = 3'd5; f = 12'(hm - SX5);
    end else if (hm >= SX4) begin
      k = 3'd4; f = 12'(hm - SX4);
    end else if (hm >= SX3) begin
      k = 3'd3; f = 12'(hm - SX3);
    end else if (hm >= SX2) begin
      k = 3'd2; f = 12'(hm - SX2);
    end else if (hm >= SX1) begin
      k = 3'd1; f = 12'(hm - SX1);
    end else begin
      k = 3'd0; f = 12'(hm);
    end
  end

  always_comb begin
    xa = XW'(s0_r) * XW'(f0_r) + XW'(hsvor_pkg::HUE_SEXT / 2);
    xb = XW'(s0_r) * XW'(12'(hsvor_pkg::HUE_SEXT) - f0_r) + XW'(hsvor_pkg::HUE_SEXT / 2);
    pa = PW'(ya1_r) * PW'(M15);
    pb = PW'(yb1_r) * PW'(M15);
    cv = chan(pv3_r);
    cp = chan(pp3_r);
    cq = chan(pq3_r);
    ct = chan(pt3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k0_r      <= k;
      f0_r      <= f;
      s0_r      <= sat;
      v0_r      <= val;
      side_r[0] <= up_side;
    end
    // divide by 3840 = shift by 8, then reciprocal of 15
    if (en[1]) begin
      ya1_r <= YW'(xa >> 8);
      yb1_r <= YW'(xb >> 8);
      s1_r  <= s0_r;
      v1_r  <= v0_r;
      k1_r  <= k0_r;
    end
    if (en[2]) begin
      sf2_r <= FW'(pa >> K15);
      sg2_r <= FW'(pb >> K15);
      s2_r  <= s1_r;
      v2_r  <= v1_r;
      k2_r  <= k1_r;
    end
    if (en[3]) begin
      pv3_r <= GW'(v2_r) << F;
      pp3_r <= GW'(v2_r) * GW'(ONE - s2_r);
      pq3_r <= GW'(v2_r) * GW'(ONE - sf2_r);
      pt3_r <= GW'(v2_r) * GW'(ONE - sg2_r);
      k3_r  <= k2_r;
    end
    if (en[4]) begin
      case (k3_r)
        3'd0: begin r4_r <= cv; g4_r <= ct; b4_r <= cp; end
        3'd1: begin r4_r <= cq; g4_r <= cv; b4_r <= cp; end
        3'd2: begin r4_r <= cp; g4_r <= cv; b4_r <= ct; end
        3'd3: begin r4_r <= cp; g4_r <= cq; b4_r <= cv; end
        3'd4: begin r4_r <= ct; g4_r <= cp; b4_r <= cv; end
        default: begin r4_r <= cv; g4_r <= cp; b4_r <= cq; end
      endcase
    end
    for (int i = 1; i < NS; i++) begin
      if (en[i]) side_r[i] <= side_r[i-1];
    end
  end

  assign red     = r4_r;
  assign green   = g4_r;
  assign blue    = b4_r;
  assign dn_side = side_r[NS-1];

endmodule

`default_nettype wire

// ===== hdl/hsvor_pass.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One override pass: analyze, swap one component, rebuild RGB.
// A disabled pass hands its input pixel through at the same latency.
module hsvor_pass #(
  parameter int F     = hsvor_pkg::FRAC_BITS,
  parameter int WHICH = hsvor_pkg::OVR_VALUE,
  parameter int SW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_stall,
  input  wire logic [7:0]    red,
  input  wire logic [7:0]    green,
  input  wire logic [7:0]    blue,
  input  wire logic [SW-1:0] up_side,
  input  wire logic          ovr_en,
  input  wire logic [16:0]   repl,
  output logic               dn_valid,
  input  wire logic          dn_stall,
  output logic      [7:0]    red_o,
  output logic      [7:0]    green_o,
  output logic      [7:0]    blue_o,
  output logic      [SW-1:0] dn_side,
  output logic      [14:0]   src_hue,
  output logic      [F:0]    src_sat,
  output logic      [F:0]    src_val
);

  localparam int FW  = F + 1;
  localparam int AW  = SW + 24;
  localparam int SYW = AW + 15 + 2 * FW;
  localparam int CW  = F + 18;
  localparam logic [FW-1:0] ONE = FW'(1) << F;

  logic           a_valid, a_stall;
  logic [14:0]    a_hue;
  logic [FW-1:0]  a_sat, a_val;
  logic [AW-1:0]  a_side;
  logic [14:0]    h_sel;
  logic [FW-1:0]  s_sel, v_sel, repl_c;
  logic [7:0]     s_red, s_green, s_blue;
  logic [SYW-1:0] s_side;
  logic [AW-1:0]  s_pass;

  hsvor_analyze #(.F(F), .SW(AW)) u_analyze (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (up_valid),
    .up_stall (up_stall),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .up_side  ({up_side, red, green, blue}),
    .dn_valid (a_valid),
    .dn_stall (a_stall),
    .hue      (a_hue),
    .sat      (a_sat),
    .val      (a_val),
    .dn_side  (a_side)
  );

  // Saturate a saturation or value replacement at 1.0, then swap it in
  always_comb begin
    repl_c = (CW'(repl) > CW'(ONE)) ? ONE : FW'(repl);
    h_sel  = a_hue;
    s_sel  = a_sat;
    v_sel  = a_val;
    if (WHICH == hsvor_pkg::OVR_HUE) h_sel = 15'(repl);
    else if (WHICH == hsvor_pkg::OVR_SAT) s_sel = repl_c;
    else v_sel = repl_c;
  end

  hsvor_synth #(.F(F), .SW(SYW)) u_synth (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (a_valid),
    .up_stall (a_stall),
    .hue      (h_sel),
    .sat      (s_sel),
    .val      (v_sel),
    .up_side  ({a_side, a_hue, a_sat, a_val}),
    .dn_valid (dn_valid),
    .dn_stall (dn_stall),
    .red      (s_red),
    .green    (s_green),
    .blue     (s_blue),
    .dn_side  (s_side)
  );

  assign s_pass  = s_side[SYW-1 -: AW];
  assign src_hue = s_side[2*FW +: 15];
  assign src_sat = s_side[FW +: FW];
  assign src_val = s_side[0 +: FW];
  assign dn_side = s_pass[AW-1 -: SW];

  always_comb begin
    if (ovr_en) begin
      red_o   = s_red;
      green_o = s_green;
      blue_o  = s_blue;
    end else begin
      red_o   = s_pass[23:16];
      green_o = s_pass[15:8];
      blue_o  = s_pass[7:0];
    end
  end

endmodule

`default_nettype wire

// ===== bench/hsv_override_recolor_unit_test.sv =====
`timescale 1ns / 1ps

module hsv_override_recolor_unit_test;

  localparam int ONE_Q = 1 << hsvor_pkg::FRAC_BITS;
  localparam int LATENCY = 31;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [16:0] sat;
    logic [16:0] val;
  } recolor_word_t;

  // Recolor predictor and the queue of pixels still owed by the block.
  class recolor_scoreboard;
    recolor_word_t owed[$];
    logic [2:0]  enables;
    logic [14:0] hue_reg;
    logic [16:0] sat_reg;
    logic [16:0] val_reg;
    int errors;

    function automatic longint unsigned div_rnd(longint unsigned n, longint unsigned d);
      return (2 * n + d) / (2 * d);
    endfunction

    function automatic void split_hsv(input longint unsigned r, g, b,
                                      output longint unsigned h, s, v);
      longint unsigned mx, mn, d, num;
      mx = (r > g) ? r : g;
      mx = (mx > b) ? mx : b;
      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      d = mx - mn;
      v = div_rnd(mx * ONE_Q, 255);
      s = (mx == 0) ? 0 : div_rnd(d * ONE_Q, mx);
      if (d == 0) begin
        h = 0;
      end else begin
        if (r == mx) begin
          num = (g >= b) ? hsvor_pkg::HUE_SEXT * (g - b)
                         : hsvor_pkg::HUE_FULL * d - hsvor_pkg::HUE_SEXT * (b - g);
        end else if (g == mx) begin
          num = hsvor_pkg::HUE_SEXT * (2 * d + b - r);
        end else begin
          num = hsvor_pkg::HUE_SEXT * (4 * d + r - g);
        end
        h = div_rnd(num, d);
        if (h >= hsvor_pkg::HUE_FULL) h -= hsvor_pkg::HUE_FULL;
      end
    endfunction

    function automatic longint unsigned scale(longint unsigned v, longint unsigned fac);
      return (v * 255 * fac + (64'd1 << (2 * hsvor_pkg::FRAC_BITS - 1)))
             >> (2 * hsvor_pkg::FRAC_BITS);
    endfunction

    function automatic void build_rgb(input longint unsigned h, s, v,
                                      output longint unsigned r, g, b);
      longint unsigned k, f, fv, fp, fq, ft;
      if (s > ONE_Q) s = ONE_Q;
      if (v > ONE_Q) v = ONE_Q;
      h = h % hsvor_pkg::HUE_FULL;
      if (s == 0) begin
        r = scale(v, ONE_Q);
        g = r;
        b = r;
        return;
      end
      k = h / hsvor_pkg::HUE_SEXT;
      f = h % hsvor_pkg::HUE_SEXT;
      fv = scale(v, ONE_Q);
      fp = scale(v, ONE_Q - s);
      fq = scale(v, ONE_Q - div_rnd(s * f, hsvor_pkg::HUE_SEXT));
      ft = scale(v, ONE_Q - div_rnd(s * (hsvor_pkg::HUE_SEXT - f), hsvor_pkg::HUE_SEXT));
      case (k)
        0: begin r = fv; g = ft; b = fp; end
        1: begin r = fq; g = fv; b = fp; end
        2: begin r = fp; g = fv; b = ft; end
        3: begin r = fp; g = fq; b = fv; end
        4: begin r = ft; g = fp; b = fv; end
        default: begin r = fv; g = fp; b = fq; end
      endcase
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] data);
      case (idx)
        hsvor_pkg::REG_ENABLES: enables = data[2:0];
        hsvor_pkg::REG_HUE:     hue_reg = data[14:0];
        hsvor_pkg::REG_SAT:     sat_reg = data;
        hsvor_pkg::REG_VAL:     val_reg = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] a, r, g, b);
      recolor_word_t w;
      longint unsigned cr, cg, cb, h, s, v;
      cr = r; cg = g; cb = b;
      split_hsv(cr, cg, cb, h, s, v);
      w.hue = h[14:0];
      w.sat = s[16:0];
      w.val = v[16:0];
      for (int p = hsvor_pkg::OVR_VALUE; p <= hsvor_pkg::OVR_HUE; p++) begin
        if (enables[p]) begin
          split_hsv(cr, cg, cb, h, s, v);
          if (p == hsvor_pkg::OVR_VALUE) v = val_reg;
          else if (p == hsvor_pkg::OVR_SAT) s = sat_reg;
          else h = hue_reg;
          build_rgb(h, s, v, cr, cg, cb);
        end
      end
      w.alpha = a;
      w.red = cr[7:0];
      w.green = cg[7:0];
      w.blue = cb[7:0];
      owed.push_back(w);
    endfunction

    function void check_pixel(recolor_word_t got);
      recolor_word_t w;
      if (owed.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      w = owed.pop_front();
      if (got.alpha !== w.alpha) begin
        $error("alpha exp %0d got %0d", w.alpha, got.alpha); errors++;
      end
      if (got.red !== w.red) begin
        $error("red exp %0d got %0d", w.red, got.red); errors++;
      end
      if (got.green !== w.green) begin
        $error("green exp %0d got %0d", w.green, got.green); errors++;
      end
      if (got.blue !== w.blue) begin
        $error("blue exp %0d got %0d", w.blue, got.blue); errors++;
      end
      if (got.hue !== w.hue) begin
        $error("src_hue exp %0d got %0d", w.hue, got.hue); errors++;
      end
      if (got.sat !== w.sat) begin
        $error("src_saturation exp %0d got %0d", w.sat, got.sat); errors++;
      end
      if (got.val !== w.val) begin
        $error("src_value exp %0d got %0d", w.val, got.val); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_alpha = '0, in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_alpha, out_red, out_green, out_blue;
  logic [14:0] out_src_hue;
  logic [16:0] out_src_saturation, out_src_value;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  recolor_scoreboard sb = new();
  int cycle_count = 0;
  bit long_hold = 1'b0;   // receiver hold-off request

  hsv_override_recolor_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles and bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every accepted output word against the oldest owed pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_pixel({out_alpha, out_red, out_green, out_blue,
                      out_src_hue, out_src_saturation, out_src_value});
  end

  // Receiver stall pattern: alternate calm stretches with random stalls,
  // and hold the output solid for a long stretch on request.
  initial begin
    int mode, len;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk);
        out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [16:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one pixel and hold it until the block takes it.
  task automatic send_pixel(logic [7:0] a, r, g, b);
    in_valid <= 1'b1;
    in_alpha <= a;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(a, r, g, b);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait until every owed pixel is out, then let the pipe drain.
  task automatic drain();
    idle_cycles(1);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_random_pixel();
    logic [7:0] r, g, b;
    int kind;
    r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
    kind = $urandom_range(0, 9);
    // Mix in greys, ties between channels and a full red channel
    if (kind == 0) begin g = r; b = r; end
    else if (kind == 1) g = r;
    else if (kind == 2) b = g;
    else if (kind == 3) r = 8'd255;
    send_pixel(8'($urandom), r, g, b);
  endtask

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        send_random_pixel();
        burst--; count--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [16:0] sv_set [4];
    sb.write_reg(hsvor_pkg::REG_ENABLES, '0);
    sb.write_reg(hsvor_pkg::REG_HUE, '0);
    sb.write_reg(hsvor_pkg::REG_SAT, '0);
    sb.write_reg(hsvor_pkg::REG_VAL, '0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no override, extremes, greys, each sextant
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h5A, 8'h80, 8'h80, 8'h80);
    send_pixel(8'h01, 8'hFF, 8'h00, 8'h00);
    send_pixel(8'h02, 8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h03, 8'h00, 8'hFF, 8'h00);
    send_pixel(8'h04, 8'h00, 8'hFF, 8'hFF);
    send_pixel(8'h05, 8'h00, 8'h00, 8'hFF);
    send_pixel(8'h06, 8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hA5, 8'hFF, 8'h00, 8'h01);
    drain();

    // Saturation override on greys tints toward red; then hue wraps and value and saturation saturate
    cfg_write(hsvor_pkg::REG_SAT, 17'd65536);
    cfg_write(hsvor_pkg::REG_ENABLES, 17'd2);
    send_pixel(8'h10, 8'h80, 8'h80, 8'h80);
    send_pixel(8'h11, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h12, 8'h00, 8'h00, 8'h00);
    drain();
    cfg_write(hsvor_pkg::REG_HUE, 17'h7FFF);
    cfg_write(hsvor_pkg::REG_VAL, 17'h1FFFF);
    cfg_write(hsvor_pkg::REG_SAT, 17'h1FFFF);
    cfg_write(hsvor_pkg::REG_ENABLES, 17'd7);
    send_pixel(8'h20, 8'h12, 8'h34, 8'h56);
    send_pixel(8'h21, 8'h80, 8'h80, 8'h80);
    send_pixel(8'h22, 8'hFF, 8'h00, 8'h00);
    drain();
    cfg_write(hsvor_pkg::REG_HUE, 17'd23039);
    cfg_write(hsvor_pkg::REG_VAL, 17'd0);
    cfg_write(hsvor_pkg::REG_SAT, 17'd0);
    send_pixel(8'h30, 8'hC0, 8'h40, 8'h20);
    drain();
    cfg_write(hsvor_pkg::REG_ENABLES, 17'd0);

    // Random phases, each with its own register setting
    sv_set = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768};
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(hsvor_pkg::REG_ENABLES,
                17'((ph == 0) ? 0 : (ph == 7) ? 7 : $urandom_range(0, 7)));
      cfg_write(hsvor_pkg::REG_HUE,
                (ph < 4) ? 17'($urandom_range(0, 32767))
                         : 17'($urandom_range(0, hsvor_pkg::HUE_FULL - 1)));
      cfg_write(hsvor_pkg::REG_SAT, (ph < 4) ? sv_set[ph] : 17'($urandom_range(0, ONE_Q)));
      cfg_write(hsvor_pkg::REG_VAL,
                (ph < 4) ? sv_set[3 - ph] : 17'($urandom_range(0, ONE_Q)));
      if (ph == 3) begin
        // Hold the receiver off while we keep offering pixels
        long_hold = 1'b1;
        random_phase(20);
        random_phase(60);
      end else begin
        random_phase(270);
      end
      drain();
    end

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hsvor_pkg.sv
hdl/hsvor_div.sv
hdl/hsvor_analyze.sv
hdl/hsvor_synth.sv
hdl/hsvor_pass.sv
hdl/hsv_override_recolor_unit.sv
bench/hsv_override_recolor_unit_test.sv
